FILE: rtl/dyadic_rational_alu_top_macros.svh
// Assertion macros for the dyadic rational ALU checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef DYADIC_RATIONAL_ALU_TOP_MACROS_SVH
`define DYADIC_RATIONAL_ALU_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define DRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define DRA_ASSERT_ALWAYS(lbl, cond, msg) \
  `DRA_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

FILE: rtl/dra_pkg.sv
// Shared types, widths and codes for the dyadic rational ALU.
// No dependencies.
package dra_pkg;

  localparam int NUM_WIDTH_DEF   = 32;
  localparam int MAX_DEN_EXP_DEF = 30;

  localparam int CMD_W    = 3;
  localparam int IN_W     = 32;
  localparam int BSEL_W   = IN_W + 1;
  localparam int DEN_W    = 32;
  localparam int RES_W    = 63;
  localparam int EXP_W    = 5;
  localparam int ACC_W    = 64;
  localparam int ACC_SH_W = $clog2(ACC_W);
  localparam int PIPE_LAT = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_NEG   = 3'd2,
    CMD_CMP   = 3'd3,
    CMD_SIMP  = 3'd4,
    CMD_CANON = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DEN  = 2'd1,
    ST_NO_CANON = 2'd2
  } status_t;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

endpackage

FILE: rtl/dra_tzc.sv
// Trailing zero counter: isolates the lowest set bit and encodes its position.
// Standalone; used by the dyadic rational ALU top level.
module dra_tzc #(
  parameter int W = 32
) (
  input  logic [W-1:0]         x,
  output logic [$clog2(W)-1:0] cnt,
  output logic                 zero
);

  localparam int CW = $clog2(W);

  logic [W-1:0] low;

  assign low  = x & (~x + W'(1));
  assign zero = (x == '0);

  // OR-encode the one-hot lowest bit
  always_comb begin
    cnt = '0;
    for (int i = 0; i < W; i++) begin
      if (low[i]) begin
        cnt = cnt | CW'(i);
      end
    end
  end

endmodule

FILE: rtl/dyadic_rational_alu_top.sv
// Dyadic rational ALU: add, subtract, negate, compare, simplify, canonical value.
// Depends on dra_pkg and dra_tzc.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------------
//  command  | in_command in_a_num in_a_den in_b_num in_b_den | taken when start && !busy
//  result   | out_res_num out_res_den out_order out_status  | out_valid for one cycle
//
// One word enters per cycle while busy is low; each result passes through the five
// register stages (decode, align, add, reduce, output) after its command is taken.
// busy is high during reset and the cycle after it, low otherwise.
// Reset clears the stage valid bits; payload registers are not reset.
// The result side has no stall: a result is presented once and then replaced.
module dyadic_rational_alu_top #(
  parameter int NUM_WIDTH   = dra_pkg::NUM_WIDTH_DEF,
  parameter int MAX_DEN_EXP = dra_pkg::MAX_DEN_EXP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [dra_pkg::CMD_W-1:0]   in_command,
  input  logic signed [dra_pkg::IN_W-1:0]    in_a_num,
  input  logic signed [dra_pkg::IN_W-1:0]    in_a_den,
  input  logic signed [dra_pkg::IN_W-1:0]    in_b_num,
  input  logic signed [dra_pkg::IN_W-1:0]    in_b_den,
  output logic                               out_valid,
  output logic signed [dra_pkg::RES_W-1:0]   out_res_num,
  output logic        [dra_pkg::DEN_W-1:0]   out_res_den,
  output logic signed [1:0]                  out_order,
  output logic        [1:0]                  out_status
);

  import dra_pkg::*;

  // ---------------------------------------------------------------- decode
  logic                    accept;
  cmd_t                    cmd_in;
  logic signed [IN_W-1:0]  a_ext, b_ext;
  logic signed [BSEL_W-1:0] b_sel;
  logic [EXP_W-1:0]        tza, tzb, ea, eb;
  logic                    za, zb, zda, zdb, oka, okb;
  logic                    s1_bad_nxt;

  logic                    busy_r;
  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  cmd_t                    s1_cmd_r;
  logic signed [IN_W-1:0]  s1_a_r;
  logic signed [BSEL_W-1:0] s1_b_r;
  logic [EXP_W-1:0]        s1_ea_r, s1_eb_r, s1_tza_r, s1_tzb_r;
  logic                    s1_za_r, s1_zb_r, s1_bad_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign cmd_in = cmd_t'(in_command);
  assign a_ext  = IN_W'(signed'(in_a_num[NUM_WIDTH-1:0]));
  assign b_ext  = IN_W'(signed'(in_b_num[NUM_WIDTH-1:0]));

  dra_tzc #(.W(IN_W)) u_tz_an (.x(a_ext),    .cnt(tza), .zero(za));
  dra_tzc #(.W(IN_W)) u_tz_bn (.x(b_ext),    .cnt(tzb), .zero(zb));
  dra_tzc #(.W(IN_W)) u_tz_ad (.x(in_a_den), .cnt(ea),  .zero(zda));
  dra_tzc #(.W(IN_W)) u_tz_bd (.x(in_b_den), .cnt(eb),  .zero(zdb));

  assign oka = !zda && !in_a_den[IN_W-1]
            && ((in_a_den & (in_a_den - IN_W'(1))) == '0)
            && (ea <= EXP_W'(MAX_DEN_EXP));
  assign okb = !zdb && !in_b_den[IN_W-1]
            && ((in_b_den & (in_b_den - IN_W'(1))) == '0)
            && (eb <= EXP_W'(MAX_DEN_EXP));

  always_comb begin
    b_sel      = BSEL_W'(b_ext);
    s1_bad_nxt = 1'b0;
    // subtract, compare and canonical all work on a - b
    if (cmd_in inside {CMD_SUB, CMD_CMP, CMD_CANON}) begin
      b_sel = -BSEL_W'(b_ext);
    end
    case (cmd_in)
      CMD_NEG, CMD_SIMP: s1_bad_nxt = !oka;
      CMD_ADD, CMD_SUB, CMD_CMP, CMD_CANON: s1_bad_nxt = !(oka && okb);
      default: s1_bad_nxt = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- align
  logic [EXP_W-1:0]         sha, shb, ka, kb, la, lq, lm;
  logic signed [IN_W-1:0]   ln;
  logic signed [ACC_W-1:0]  s2_x_nxt, s2_y_nxt;
  logic signed [BSEL_W-1:0] s2_u_nxt;
  logic [EXP_W-1:0]         s2_ue_nxt, s2_cs_nxt, s2_emax_nxt;

  cmd_t                     s2_cmd_r;
  logic signed [ACC_W-1:0]  s2_x_r, s2_y_r;
  logic signed [BSEL_W-1:0] s2_u_r;
  logic [EXP_W-1:0]         s2_ue_r, s2_cs_r, s2_emax_r, s2_ea_r;
  logic                     s2_eq_r, s2_bad_r;

  always_comb begin
    sha = '0;
    shb = '0;
    if (s1_eb_r > s1_ea_r) begin
      sha = s1_eb_r - s1_ea_r;
    end
    if (s1_ea_r > s1_eb_r) begin
      shb = s1_ea_r - s1_eb_r;
    end
    // drop common factors of two; a zero numerator goes over 1
    ka = s1_za_r ? s1_ea_r : ((s1_tza_r < s1_ea_r) ? s1_tza_r : s1_ea_r);
    kb = s1_zb_r ? s1_eb_r : ((s1_tzb_r < s1_eb_r) ? s1_tzb_r : s1_eb_r);
    la = s1_ea_r - ka;
    lq = s1_eb_r - kb;
    lm = (la > lq) ? la : lq;
    ln = s1_a_r >>> ka;

    s2_x_nxt    = ACC_W'(s1_a_r) <<< sha;
    s2_y_nxt    = ACC_W'(s1_b_r) <<< shb;
    s2_cs_nxt   = lm - la + EXP_W'(1);
    s2_emax_nxt = (s1_ea_r > s1_eb_r) ? s1_ea_r : s1_eb_r;

    case (s1_cmd_r)
      CMD_NEG: begin
        s2_u_nxt  = -BSEL_W'(s1_a_r);
        s2_ue_nxt = s1_ea_r;
      end
      CMD_CANON: begin
        s2_u_nxt  = BSEL_W'(ln);
        s2_ue_nxt = lm + EXP_W'(1);
      end
      default: begin
        s2_u_nxt  = BSEL_W'(ln);
        s2_ue_nxt = la;
      end
    endcase
  end

  // ---------------------------------------------------------------- add
  logic signed [ACC_W-1:0] s3_sum_nxt, s3_u_nxt;

  cmd_t                    s3_cmd_r;
  logic signed [ACC_W-1:0] s3_sum_r, s3_u_r;
  logic [EXP_W-1:0]        s3_ue_r, s3_emax_r, s3_ea_r;
  logic                    s3_eq_r, s3_bad_r;

  always_comb begin
    s3_sum_nxt = s2_x_r + s2_y_r;
    if (s2_cmd_r == CMD_CANON) begin
      // left plus half the finer unit
      s3_u_nxt = (ACC_W'(s2_u_r) <<< s2_cs_r) | ACC_W'(1);
    end else begin
      s3_u_nxt = ACC_W'(s2_u_r);
    end
  end

  // ---------------------------------------------------------------- reduce
  logic [ACC_SH_W-1:0]     tzs;
  logic                    zs;
  logic [EXP_W-1:0]        ks;
  logic signed [ACC_W-1:0] s4_val_nxt;
  logic [EXP_W-1:0]        s4_sh_nxt, s4_e_nxt;
  logic [1:0]              s4_ord_nxt;
  status_t                 s4_st_nxt;

  logic signed [ACC_W-1:0] s4_val_r;
  logic [EXP_W-1:0]        s4_sh_r, s4_e_r;
  logic [1:0]              s4_ord_r;
  status_t                 s4_st_r;

  dra_tzc #(.W(ACC_W)) u_tz_sum (.x(s3_sum_r), .cnt(tzs), .zero(zs));

  always_comb begin
    if (zs) begin
      ks = s3_ea_r;
    end else if (tzs < ACC_SH_W'(s3_ea_r)) begin
      ks = EXP_W'(tzs);
    end else begin
      ks = s3_ea_r;
    end

    s4_val_nxt = '0;
    s4_sh_nxt  = '0;
    s4_e_nxt   = '0;
    s4_ord_nxt = ORD_EQ;
    s4_st_nxt  = ST_OK;
    if (s3_bad_r) begin
      s4_st_nxt = ST_BAD_DEN;
    end else begin
      case (s3_cmd_r)
        CMD_ADD, CMD_SUB: begin
          s4_val_nxt = s3_sum_r;
          if (s3_eq_r) begin
            s4_sh_nxt = ks;
            s4_e_nxt  = s3_ea_r - ks;
          end else begin
            s4_e_nxt = s3_emax_r;
          end
        end
        CMD_CMP: begin
          s4_ord_nxt = s3_sum_r[ACC_W-1] ? ORD_LT : (zs ? ORD_EQ : ORD_GT);
        end
        CMD_NEG, CMD_SIMP: begin
          s4_val_nxt = s3_u_r;
          s4_e_nxt   = s3_ue_r;
        end
        CMD_CANON: begin
          if (!s3_sum_r[ACC_W-1]) begin
            s4_st_nxt = ST_NO_CANON;
          end else begin
            s4_val_nxt = s3_u_r;
            s4_e_nxt   = s3_ue_r;
          end
        end
        default: s4_st_nxt = ST_OK;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [RES_W-1:0] out_res_num_nxt, out_res_num_r;
  logic [DEN_W-1:0]        out_res_den_nxt, out_res_den_r;
  logic [1:0]              out_order_r;
  status_t                 out_status_r;

  assign out_res_num_nxt = RES_W'(s4_val_r >>> s4_sh_r);
  assign out_res_den_nxt = DEN_W'(1) << s4_e_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_v_r      <= accept;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r  <= cmd_in;
    s1_a_r    <= a_ext;
    s1_b_r    <= b_sel;
    s1_ea_r   <= ea;
    s1_eb_r   <= eb;
    s1_tza_r  <= tza;
    s1_tzb_r  <= tzb;
    s1_za_r   <= za;
    s1_zb_r   <= zb;
    s1_bad_r  <= s1_bad_nxt;

    s2_cmd_r  <= s1_cmd_r;
    s2_x_r    <= s2_x_nxt;
    s2_y_r    <= s2_y_nxt;
    s2_u_r    <= s2_u_nxt;
    s2_ue_r   <= s2_ue_nxt;
    s2_cs_r   <= s2_cs_nxt;
    s2_emax_r <= s2_emax_nxt;
    s2_ea_r   <= s1_ea_r;
    s2_eq_r   <= (s1_ea_r == s1_eb_r);
    s2_bad_r  <= s1_bad_r;

    s3_cmd_r  <= s2_cmd_r;
    s3_sum_r  <= s3_sum_nxt;
    s3_u_r    <= s3_u_nxt;
    s3_ue_r   <= s2_ue_r;
    s3_emax_r <= s2_emax_r;
    s3_ea_r   <= s2_ea_r;
    s3_eq_r   <= s2_eq_r;
    s3_bad_r  <= s2_bad_r;

    s4_val_r  <= s4_val_nxt;
    s4_sh_r   <= s4_sh_nxt;
    s4_e_r    <= s4_e_nxt;
    s4_ord_r  <= s4_ord_nxt;
    s4_st_r   <= s4_st_nxt;

    out_res_num_r <= out_res_num_nxt;
    out_res_den_r <= out_res_den_nxt;
    out_order_r   <= s4_ord_r;
    out_status_r  <= s4_st_r;
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_res_num_r;
  assign out_res_den = out_res_den_r;
  assign out_order   = out_order_r;
  assign out_status  = out_status_r;

endmodule

FILE: rtl/dra_chk.sv
// Port-level checker for the dyadic rational ALU, bound to the top level.
// Depends on dra_pkg and dyadic_rational_alu_top_macros.svh.
`include "dyadic_rational_alu_top_macros.svh"

module dra_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [dra_pkg::RES_W-1:0] out_res_num,
  input logic        [dra_pkg::DEN_W-1:0] out_res_den,
  input logic signed [1:0]                out_order,
  input logic        [1:0]                out_status
);

  import dra_pkg::*;

  // every taken word gives a result, and a result comes only from a taken word
  `DRA_ASSERT_IMP(a_lat_fwd, start && !busy, ##PIPE_LAT out_valid, "result missing after command")
  `DRA_ASSERT_IMP(a_lat_bwd, out_valid, $past(start && !busy, PIPE_LAT), "result without command")

  `DRA_ASSERT_IMP(a_den_pow2, out_valid,
    out_res_den != '0 && (out_res_den & (out_res_den - DEN_W'(1))) == '0,
    "result denominator not a power of two")

  `DRA_ASSERT_ALWAYS(a_err_zero,
    !(out_valid && out_status != ST_OK) ||
    (out_res_num == '0 && out_res_den == DEN_W'(1) && out_order == ORD_EQ),
    "error result carries a value")

  `DRA_ASSERT_IMP(a_ord_zero, out_valid && out_order != ORD_EQ,
    out_res_num == '0 && out_res_den == DEN_W'(1) && out_status == ST_OK,
    "compare result carries a value")

endmodule

bind dyadic_rational_alu_top dra_chk u_dra_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_res_num (out_res_num),
  .out_res_den (out_res_den),
  .out_order   (out_order),
  .out_status  (out_status)
);
